// File: rtl/knn_pkg.sv
// shared types, constants and defaults for the knn binary classifier
package knn_pkg;

  localparam int unsigned MAX_NEIGHBOURS_DEF = 16;
  localparam int unsigned MAX_FEATURES_DEF   = 64;

  localparam int unsigned FEAT_W = 16;
  localparam int unsigned DIFF_W = FEAT_W + 1;
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned DIST_W = 40;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned CNT_W  = 5;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CFG_W-1:0] NCOUNT_RESET = CFG_W'(1);

  // register index is paddr divided by four
  localparam logic REG_NEIGHBOUR_COUNT = 1'b0;

  localparam logic OP_QUERY     = 1'b0;
  localparam logic OP_REFERENCE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic signed [FEAT_W-1:0] feature_value;
    logic              ref_label;
    logic              last_feature;
    logic              last_reference;
  } knn_in_t;

  typedef struct packed {
    logic             predicted_positive;
    logic [CNT_W-1:0] positive_votes;
    logic [CNT_W-1:0] neighbours_kept;
  } knn_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_INSERT,
    S_VOTE
  } knn_state_e;

  typedef struct packed {
    logic ins;
    logic clear;
    logic label;
  } knn_list_cmd_t;

endpackage

// File: rtl/knn_if.sv
// valid/ready channel interfaces for request and result words
interface knn_req_if
  import knn_pkg::*;
  ();
  logic    valid;
  logic    ready;
  knn_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface knn_rsp_if
  import knn_pkg::*;
  ();
  logic     valid;
  logic     ready;
  knn_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/knn_ram.sv
// generic single-port ram with registered read
module knn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/knn_list.sv
// sorted list of the k nearest references with parallel insert and vote count
module knn_list
  import knn_pkg::*;
#(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  knn_list_cmd_t     cmd_i,
  input  logic [CW-1:0]     k_i,
  input  logic [DIST_W-1:0] cand_i,
  output logic [CW-1:0]     votes_o,
  output logic [CW-1:0]     kept_o
);

  logic [DIST_W-1:0]         dist_q [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]         dist_d [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS-1:0] label_q, label_d;
  logic [MAX_NEIGHBOURS-1:0] le;
  logic [CW-1:0]             fill_q, fill_d, fill;
  logic [CW-1:0]             votes;

  assign fill = (fill_q < k_i) ? fill_q : k_i;

  // entries no further than the candidate stay, the rest move down one place
  always_comb begin
    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      le[i] = (CW'(i) < fill) && (dist_q[i] <= cand_i);
    end
    dist_d  = dist_q;
    label_d = label_q;
    if (!le[0]) begin
      dist_d[0]  = cand_i;
      label_d[0] = cmd_i.label;
    end
    for (int i = 1; i < MAX_NEIGHBOURS; i++) begin
      if (!le[i]) begin
        if (le[i-1]) begin
          dist_d[i]  = cand_i;
          label_d[i] = cmd_i.label;
        end else begin
          dist_d[i]  = dist_q[i-1];
          label_d[i] = label_q[i-1];
        end
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.ins) begin
      fill_d = (fill < k_i) ? fill + CW'(1) : k_i;
    end
  end

  always_comb begin
    votes = '0;
    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      votes = votes + CW'((CW'(i) < fill) && label_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      dist_q  <= dist_d;
      label_q <= label_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign votes_o = votes;
  assign kept_o  = fill;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_NEIGHBOURS))
    else $error("list fill beyond capacity");
  a_ins_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins && !cmd_i.clear) |=> fill_q != '0)
    else $error("insert left the list empty");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> fill_q == '0)
    else $error("clear did not empty the list");
`endif

endmodule

// File: rtl/knn_binary_classifier_top.sv
// knn binary classifier: query store, distance accumulation, nearest list and vote
// query item: stored in the query ram; ready again the next cycle
// reference feature: ram read, square, accumulate; final feature adds an insert step
// final reference: a vote step follows, result registered; waits only on a held result
// sequencing is set by the single-port query ram and the one-item-at-a-time state machine
// reset: k = 1, list empty, distance and position zero; query ram contents undefined
module knn_binary_classifier_top
  import knn_pkg::*;
#(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int unsigned MAX_FEATURES   = MAX_FEATURES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  knn_req_if.sink           req_i,
  knn_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned KW = (CW > CFG_W) ? CW : CFG_W;

  knn_state_e state_q, state_d;

  logic [CFG_W-1:0]  ncount_q;
  logic [KW-1:0]     ncount_ext;
  logic [CW-1:0]     k_eff;

  logic [PW-1:0]     pos_q, pos_d, pos_next;
  logic [PW:0]       pos_inc;

  logic signed [FEAT_W-1:0] val_q;
  logic              label_q, lastf_q, lastr_q;
  logic [FEAT_W-1:0] q_rdata;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]   sq_q;
  logic [DIST_W-1:0] dist_q, dist_d, cand_q;
  logic [DIST_W:0]   acc;

  logic              req_ready, req_fire;
  logic              ram_en, ram_we;
  logic              cand_load, out_load;
  knn_list_cmd_t     list_cmd;
  logic [CW-1:0]     votes, kept;

  knn_out_t          out_q;
  logic              out_valid_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEIGHBOUR_COUNT) ? APB_DW'(ncount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= NCOUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_NEIGHBOUR_COUNT)) begin
      ncount_q <= pwdata[CFG_W-1:0];
    end
  end

  // k clamped to 1..MAX_NEIGHBOURS
  assign ncount_ext = KW'(ncount_q);
  always_comb begin
    if (ncount_ext == '0) begin
      k_eff = CW'(1);
    end else if (ncount_ext > KW'(MAX_NEIGHBOURS)) begin
      k_eff = CW'(MAX_NEIGHBOURS);
    end else begin
      k_eff = CW'(ncount_ext);
    end
  end

  assign pos_inc  = {1'b0, pos_q} + (PW+1)'(1);
  assign pos_next = (pos_inc >= (PW+1)'(MAX_FEATURES)) ? '0 : pos_inc[PW-1:0];

  assign req_i.ready = req_ready;
  assign req_fire    = req_i.valid && req_ready;

  knn_ram #(
    .WIDTH (FEAT_W),
    .DEPTH (MAX_FEATURES)
  ) u_query_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (pos_q),
    .wdata_i (req_i.data.feature_value),
    .rdata_o (q_rdata)
  );

  assign diff = {val_q[FEAT_W-1], val_q} - {q_rdata[FEAT_W-1], q_rdata};
  assign prod = diff * diff;
  // saturating distance add
  assign acc  = {1'b0, dist_q} + (DIST_W+1)'(sq_q);

  always_comb begin
    state_d   = state_q;
    req_ready = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    pos_d     = pos_q;
    dist_d    = dist_q;
    cand_load = 1'b0;
    out_load  = 1'b0;
    list_cmd  = '{ins: 1'b0, clear: 1'b0, label: label_q};
    unique case (state_q)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_fire) begin
          ram_en = 1'b1;
          pos_d  = req_i.data.last_feature ? '0 : pos_next;
          if (req_i.data.operation == OP_QUERY) begin
            ram_we = 1'b1;
          end else begin
            state_d = S_SQUARE;
          end
        end
      end
      S_SQUARE: begin
        state_d = S_ACCUM;
      end
      S_ACCUM: begin
        if (lastf_q) begin
          cand_load = 1'b1;
          dist_d    = '0;
          state_d   = S_INSERT;
        end else begin
          dist_d  = acc[DIST_W] ? '1 : acc[DIST_W-1:0];
          state_d = S_IDLE;
        end
      end
      S_INSERT: begin
        list_cmd.ins = 1'b1;
        state_d      = lastr_q ? S_VOTE : S_IDLE;
      end
      S_VOTE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load       = 1'b1;
          list_cmd.clear = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      dist_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      dist_q  <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      val_q   <= req_i.data.feature_value;
      label_q <= req_i.data.ref_label;
      lastf_q <= req_i.data.last_feature;
      lastr_q <= req_i.data.last_reference;
    end
    if (state_q == S_SQUARE) begin
      sq_q <= prod[SQ_W-1:0];
    end
    if (cand_load) begin
      cand_q <= acc[DIST_W] ? '1 : acc[DIST_W-1:0];
    end
  end

  knn_list #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (list_cmd),
    .k_i     (k_eff),
    .cand_i  (cand_q),
    .votes_o (votes),
    .kept_o  (kept)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.predicted_positive <= votes > (k_eff >> 1);
      out_q.positive_votes     <= CNT_W'(votes);
      out_q.neighbours_kept    <= CNT_W'(kept);
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_vote_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VOTE && !out_load) |-> out_valid_q)
    else $error("vote stalled with no result word pending");
  a_ref_to_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.data.operation == OP_REFERENCE) |=> state_q == S_SQUARE)
    else $error("reference word did not start the distance step");
  a_result_from_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_VOTE))
    else $error("result word raised outside the vote step");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW+1)'(pos_q) < (PW+1)'(MAX_FEATURES))
    else $error("feature position out of range");
`endif

endmodule

// File: tb/knn_vote_checker.sv
`timescale 1ns / 100ps
// watches the knn channels and k writes, predicts every vote and compares the result words
module knn_vote_checker
  import knn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  knn_req_if                req_i,
  knn_rsp_if                rsp_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fault_count_o,
  output int                outstanding_o
);

  logic [CFG_W-1:0]  k_reg;
  logic [FEAT_W-1:0] query_mem [MAX_FEATURES_DEF];
  int                feat_pos;
  logic [DIST_W-1:0] dist_acc;
  logic [DIST_W-1:0] nearest_dist [MAX_NEIGHBOURS_DEF];
  logic              nearest_label [MAX_NEIGHBOURS_DEF];
  int                nearest_fill;
  knn_out_t          votes_due [$];
  int                faults = 0;

  // register values outside 1..MAX act as the nearest bound
  function automatic int active_k();
    if (k_reg == '0) return 1;
    if (k_reg > MAX_NEIGHBOURS_DEF) return MAX_NEIGHBOURS_DEF;
    return int'(k_reg);
  endfunction

  task automatic insert_nearest(logic [DIST_W-1:0] cand_dist, logic label);
    int kk;
    int fill;
    int slot;
    int j;
    kk = active_k();
    fill = (nearest_fill < kk) ? nearest_fill : kk;
    slot = 0;
    // equal distance keeps the earlier reference ahead
    while (slot < fill && nearest_dist[slot] <= cand_dist) slot++;
    if (slot >= kk) begin
      nearest_fill = fill;
    end else begin
      for (j = (fill < kk) ? fill : kk - 1; j > slot; j--) begin
        nearest_dist[j] = nearest_dist[j-1];
        nearest_label[j] = nearest_label[j-1];
      end
      nearest_dist[slot] = cand_dist;
      nearest_label[slot] = label;
      nearest_fill = (fill < kk) ? fill + 1 : kk;
    end
  endtask

  task automatic track_word(knn_in_t w);
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] mag;
    logic [SQ_W-1:0]   sq;
    logic [DIST_W:0]   total;
    int                slot;
    int                next_slot;
    int                kk;
    int                kept;
    int                votes;
    int                i;
    knn_out_t          res;
    slot = feat_pos;
    next_slot = (slot == MAX_FEATURES_DEF - 1) ? 0 : slot + 1;
    if (w.operation == OP_QUERY) begin
      query_mem[slot] = w.feature_value;
      feat_pos = w.last_feature ? 0 : next_slot;
    end else begin
      diff = {w.feature_value[FEAT_W-1], w.feature_value}
           - {query_mem[slot][FEAT_W-1], query_mem[slot]};
      mag = diff[DIFF_W-1] ? -diff : diff;
      sq = SQ_W'(mag) * SQ_W'(mag);
      total = {1'b0, dist_acc} + (DIST_W+1)'(sq);
      dist_acc = total[DIST_W] ? '1 : total[DIST_W-1:0];
      if (!w.last_feature) begin
        feat_pos = next_slot;
      end else begin
        feat_pos = 0;
        insert_nearest(dist_acc, w.ref_label);
        dist_acc = '0;
        if (w.last_reference) begin
          kk = active_k();
          kept = (nearest_fill < kk) ? nearest_fill : kk;
          votes = 0;
          for (i = 0; i < kept; i++) votes += int'(nearest_label[i]);
          res.predicted_positive = (votes > kk / 2);
          res.positive_votes = CNT_W'(votes);
          res.neighbours_kept = CNT_W'(kept);
          votes_due.push_back(res);
          nearest_fill = 0;
        end
      end
    end
  endtask

  task automatic check_result(knn_out_t got);
    knn_out_t want;
    if (votes_due.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("unexpected result word: pred %0d votes %0d kept %0d",
                 got.predicted_positive, got.positive_votes, got.neighbours_kept);
    end else begin
      want = votes_due.pop_front();
      if (got.predicted_positive !== want.predicted_positive ||
          got.positive_votes !== want.positive_votes ||
          got.neighbours_kept !== want.neighbours_kept) begin
        faults++;
        if (faults <= 10)
          $display("result mismatch: expected pred %0d votes %0d kept %0d, got %0d %0d %0d",
                   want.predicted_positive, want.positive_votes, want.neighbours_kept,
                   got.predicted_positive, got.positive_votes, got.neighbours_kept);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_reg = NCOUNT_RESET;
      feat_pos = 0;
      dist_acc = '0;
      nearest_fill = 0;
      votes_due.delete();
      fault_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_NEIGHBOUR_COUNT)
        k_reg = pwdata[CFG_W-1:0];
      // a result word can never stem from a word accepted at the same edge
      if (rsp_i.valid && rsp_i.ready) check_result(rsp_i.data);
      if (req_i.valid && req_i.ready) track_word(req_i.data);
      fault_count_o <= faults;
      outstanding_o <= votes_due.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// knn classifier bench: directed and random query sets, k writes over apb, final verdict
module testbench;
  import knn_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int WORD_TARGET     = 1200;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              req_valid_q = 1'b0;
  knn_in_t           req_data_q = '0;
  logic              rsp_ready_q = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              calm = 1'b0;
  int                fault_count;
  int                outstanding;
  int                cycles = 0;
  int                words_sent = 0;
  int                gen_pos = 0;
  logic [MAX_FEATURES_DEF-1:0] written = '0;

  knn_req_if req_if ();
  knn_rsp_if rsp_if ();

  assign req_if.valid = req_valid_q;
  assign req_if.data  = req_data_q;
  assign rsp_if.ready = rsp_ready_q;

  knn_binary_classifier_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  knn_vote_checker vote_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fault_count_o (fault_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    rsp_ready_q <= calm || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("knn_binary_classifier_top verification failed");
      $finish;
    end
  end

  function automatic logic [FEAT_W-1:0] pick_value(int mode);
    case (mode)
      0: return FEAT_W'($urandom_range(6)) - FEAT_W'(3);
      1: return FEAT_W'($urandom());
      default: begin
        case ($urandom_range(3))
          0: return {1'b1, {(FEAT_W-1){1'b0}}};
          1: return {1'b0, {(FEAT_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_k();
    case ($urandom_range(7))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(MAX_NEIGHBOURS_DEF);
      3: return CFG_W'(MAX_NEIGHBOURS_DEF + 1);
      4: return '1;
      default: return CFG_W'($urandom_range(31));
    endcase
  endfunction

  // a reference word is only sent where its query entry has been written
  task automatic put(logic op, logic [FEAT_W-1:0] val, logic label, logic lastf, logic lastr);
    knn_in_t w;
    w.operation = op;
    w.feature_value = val;
    w.ref_label = label;
    w.last_feature = lastf;
    w.last_reference = lastr;
    if (op == OP_REFERENCE && !written[gen_pos]) w.operation = OP_QUERY;
    if (w.operation == OP_QUERY) written[gen_pos] = 1'b1;
    gen_pos = lastf ? 0 : (gen_pos + 1) % MAX_FEATURES_DEF;
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        req_valid_q <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_data_q <= w;
    req_valid_q <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
  endtask

  // hold off until every vote is back and the pipeline has had time to settle
  task automatic drain(int extra);
    req_valid_q <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_k(logic [CFG_W-1:0] k);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({REG_NEIGHBOUR_COUNT, 2'b00});
    pwdata <= {(APB_DW-CFG_W)'($urandom()), k};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int i;
    int r;
    int set_no;
    int shape;
    int vec_len;
    int q_len;
    int refs;
    int mode;
    int p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes at k = 1, end marks set on words that must ignore them
    put(OP_QUERY, 16'h7fff, 1'b1, 1'b0, 1'b1);
    put(OP_QUERY, 16'h8000, 1'b0, 1'b1, 1'b1);
    put(OP_REFERENCE, 16'h8000, 1'b0, 1'b0, 1'b1);
    put(OP_REFERENCE, 16'h7fff, 1'b1, 1'b1, 1'b0);
    put(OP_REFERENCE, 16'h7fff, 1'b1, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'h8000, 1'b0, 1'b1, 1'b1);

    // k of zero acts as one; equal distance keeps the first reference
    drain(12);
    write_k('0);
    put(OP_REFERENCE, 16'd5, 1'b0, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'd7, 1'b1, 1'b1, 1'b0);
    put(OP_REFERENCE, 16'd5, 1'b1, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'd7, 1'b0, 1'b1, 1'b1);

    // k above the limit, list only partly filled
    drain(12);
    write_k('1);
    put(OP_REFERENCE, 16'd1, 1'b0, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'd2, 1'b1, 1'b1, 1'b0);
    put(OP_REFERENCE, 16'd3, 1'b1, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'd4, 1'b1, 1'b1, 1'b0);
    put(OP_REFERENCE, 16'd5, 1'b1, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'd6, 1'b0, 1'b1, 1'b1);

    // k = 2, the farthest of three references drops out
    drain(12);
    write_k(CFG_W'(2));
    put(OP_REFERENCE, 16'h7fff, 1'b0, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'h8000, 1'b1, 1'b1, 1'b0);
    put(OP_REFERENCE, 16'h0000, 1'b1, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'h0000, 1'b0, 1'b1, 1'b0);
    put(OP_REFERENCE, 16'h7ffe, 1'b1, 1'b0, 1'b0);
    put(OP_REFERENCE, 16'h8000, 1'b1, 1'b1, 1'b1);

    // full query store, then one long reference that saturates the distance
    for (i = 0; i < MAX_FEATURES_DEF; i++)
      put(OP_QUERY, 16'h8000, 1'b0, i == MAX_FEATURES_DEF - 1, 1'b0);
    for (i = 0; i < 300; i++)
      put(OP_REFERENCE, 16'h7fff, 1'b1, i == 299, 1'b1);
    // query longer than the store wraps the position
    for (i = 0; i < 70; i++)
      put(OP_QUERY, pick_value(1), 1'($urandom_range(1)), i == 69, 1'b0);

    set_no = 0;
    while (words_sent < WORD_TARGET) begin
      set_no++;
      calm <= (set_no >= 12 && set_no < 20);
      if ($urandom_range(99) < 12) begin
        drain(12);
        write_k(pick_k());
      end
      shape = $urandom_range(99);
      mode = $urandom_range(2);
      p = $urandom_range(99);
      vec_len = (p < 90) ? $urandom_range(6, 1) :
                (p < 98) ? $urandom_range(MAX_FEATURES_DEF, 7) : $urandom_range(70, 65);
      refs = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(20, 10);
      if (shape < 10) begin
        repeat ($urandom_range(20, 5))
          put(1'($urandom_range(1)), pick_value($urandom_range(2)), 1'($urandom_range(1)),
              $urandom_range(3) == 0, 1'($urandom_range(1)));
      end else begin
        // query then references; when shape < 20 the query length differs and the set may be left open
        q_len = (shape < 20) ? $urandom_range(8, 1) : vec_len;
        for (i = 0; i < q_len; i++)
          put(OP_QUERY, pick_value(mode), 1'($urandom_range(1)), i == q_len - 1,
              1'($urandom_range(1)));
        for (r = 0; r < refs; r++) begin
          // k changed between references of one set
          if (r != 0 && $urandom_range(99) < 5) begin
            drain(12);
            write_k(pick_k());
          end
          for (i = 0; i < vec_len; i++)
            put(OP_REFERENCE, pick_value(mode), 1'($urandom_range(1)), i == vec_len - 1,
                (i == vec_len - 1) ? (r == refs - 1 && !(shape < 20 && $urandom_range(3) == 0))
                                   : logic'($urandom_range(1)));
        end
      end
    end

    calm <= 1'b0;
    drain(20);
    if (fault_count == 0 && outstanding == 0) begin
      $display("knn_binary_classifier_top verification clean");
    end else begin
      $display("knn_binary_classifier_top verification failed");
    end
    $finish;
  end

endmodule
